FILE: rtl/vppt_pkg.sv
package vppt_pkg;

  // Coordinate and table formats
  localparam int COORD_W           = 24;
  localparam int COORD_FRAC_BITS   = 8;
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES);
  localparam int EXP_TAB_W         = 31;   // 2^(-r/E) in Q0.30, entry zero is exactly 1.0
  localparam int FACTOR_W          = 19;   // unsigned Q3.16, at most 4.0
  localparam int DIFF_W            = COORD_W + 1;

  // Depth scaling: n = floor((d + DEPTH_BIAS) / DEPTH_DIV), one table step per DEPTH_DIV
  localparam int DEPTH_UNITS = 750;
  localparam int DEPTH_DIV   = DEPTH_UNITS * (2 ** COORD_FRAC_BITS) / EXP_TABLE_ENTRIES;
  localparam int DEPTH_BIAS  = DEPTH_DIV / 2;
  localparam int DEPTH_MIN   = -2 * DEPTH_UNITS * (2 ** COORD_FRAC_BITS);

  // Offset depth, always positive after the clamp; n is then floor(u / DEPTH_DIV) - 2E
  localparam int U_W    = COORD_W;
  localparam int U_BIAS = DEPTH_BIAS - DEPTH_MIN;
  localparam int Q_W    = 14;

  // Reciprocal of DEPTH_DIV, rounded down; one correction step follows
  localparam int                RECIP_SHIFT = 34;
  localparam int                RECIP_W     = 25;
  localparam logic [63:0]       RECIP_M64   = (64'd1 << RECIP_SHIFT) / DEPTH_DIV;
  localparam logic [RECIP_W-1:0] RECIP_M    = RECIP_M64[RECIP_W-1:0];
  localparam int                PROD_W      = U_W + RECIP_W;

  // Factor shift is 14 + floor(n / E); the 2E offset in u takes two off the base
  localparam int SH_W        = 6;
  localparam int FSHIFT_BASE = 12;

  // Latencies
  localparam int FACTOR_LAT = 4;
  localparam int PIPE_LAT   = FACTOR_LAT + 3;

  typedef enum logic [1:0] {
    ACT_SIDE  = 2'd0,
    ACT_FLOOR = 2'd1,
    ACT_BACK  = 2'd2,
    ACT_PASS  = 2'd3
  } action_t;

  typedef logic [EXP_TAB_W-1:0] exp_tab_t [EXP_TABLE_ENTRIES];

  localparam logic [63:0] LN2_Q48 = 64'hB17217F7D1CF;

  // Power series for 2^(-r/E), worked out at elaboration
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] z48;
    logic [63:0] z;
    logic [63:0] term;
    longint      sum;
    for (int r = 0; r < EXP_TABLE_ENTRIES; r++) begin
      z48  = (64'(r) * LN2_Q48) / EXP_TABLE_ENTRIES;
      z    = (z48 + (64'd1 << 17)) >> 18;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int k = 1; k <= 24; k++) begin
        term = ((term * z) >> 30) / 64'(k);
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      tab[r] = sum[EXP_TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP2_TAB = build_exp_tab();

endpackage

FILE: rtl/vppt_factor.sv
module vppt_factor
  import vppt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [U_W-1:0]      in_u,
  output logic                out_valid,
  output logic [FACTOR_W-1:0] out_factor
);

  logic [3:0] valid_r;

  // Stage A: reciprocal product
  logic [PROD_W-1:0] prod_r;
  logic [U_W-1:0]    ua_r;

  // Stage B: corrected quotient
  logic [Q_W-1:0] q0;
  logic [U_W:0]   rem;
  logic [Q_W-1:0] q_r, q_nxt;

  // Stage C: table entry and shift
  logic [EXP_TAB_W-1:0] tab_r;
  logic [SH_W-1:0]      sh_r;

  // Stage D: rounded factor
  logic [32:0]         rsum;
  logic [FACTOR_W-1:0] f_r, f_nxt;

  always_comb begin
    q0    = prod_r[RECIP_SHIFT +: Q_W];
    rem   = {1'b0, ua_r} - (U_W + 1)'(q0 * (U_W + 1)'(DEPTH_DIV));
    q_nxt = (rem >= (U_W + 1)'(DEPTH_DIV)) ? q0 + Q_W'(1) : q0;
  end

  always_comb begin
    rsum  = '0;
    f_nxt = '0;
    if (sh_r <= SH_W'(31)) begin
      rsum  = {2'b00, tab_r} + (33'd1 << (sh_r - SH_W'(1)));
      f_nxt = FACTOR_W'(rsum >> sh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(in_u) * PROD_W'(RECIP_M);
    ua_r   <= in_u;
    q_r    <= q_nxt;
    tab_r  <= EXP2_TAB[q_r[EXP_IDX_W-1:0]];
    sh_r   <= SH_W'(FSHIFT_BASE) + SH_W'(q_r[Q_W-1:EXP_IDX_W]);
    f_r    <= f_nxt;
  end

  assign out_valid  = valid_r[3];
  assign out_factor = f_r;

endmodule

FILE: rtl/vanishing_plane_point_transform.sv
// Vanishing-plane point transform. One point is taken in every clock cycle
// (busy stays low once reset is over) and its result appears on out_x,
// out_y and out_clipped, flagged by a one-cycle out_valid. The receiver
// cannot stall the block: a result is gone after its strobe cycle, so
// capture it then. The pipeline stages are the depth select and clamp,
// four stages of the blend-factor unit (reciprocal multiply by the depth
// step, quotient correction, exp2 table read, rounding shift), the blend
// multiply and the final round, add and saturate. The factor is
// 0.5^(depth/750) in unsigned Q3.16, the depth being clamped at -1500 so
// the factor never exceeds 4; out_clipped reports that clamp or an output
// saturating. Pass-through items return the point unchanged and unclipped.
module vanishing_plane_point_transform
  import vppt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_intercept,
  input  logic signed [COORD_W-1:0] in_vanish_x,
  input  logic signed [COORD_W-1:0] in_vanish_y,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic                      out_clipped
);

  typedef struct packed {
    logic [1:0]                action;
    logic                      clip;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } item_t;

  logic accept;
  logic busy_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Hold busy through reset so no transfer lands in a clearing pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: pick depth and blend targets, clamp depth, form differences
  // ---------------------------------------------------------------------
  logic signed [COORD_W-1:0] depth, tx, ty, depth_cl;
  logic                      clamp;
  logic [U_W:0]              u_wide;
  item_t                     s1_nxt, s1_r;
  logic                      s1_valid_r;
  logic [U_W-1:0]            u_r;

  always_comb begin
    case (action_t'(in_action))
      ACT_SIDE: begin
        depth = in_point_x;
        tx    = in_intercept;
        ty    = in_point_y;
      end
      ACT_FLOOR: begin
        depth = in_point_y;
        tx    = in_point_x;
        ty    = in_intercept;
      end
      ACT_BACK, ACT_PASS: begin
        depth = in_intercept;
        tx    = in_point_x;
        ty    = in_point_y;
      end
      default: begin
        depth = in_intercept;
        tx    = in_point_x;
        ty    = in_point_y;
      end
    endcase

    clamp    = (depth < COORD_W'(DEPTH_MIN));
    depth_cl = clamp ? COORD_W'(DEPTH_MIN) : depth;
    // Offset keeps the quotient positive; at most 24 bits after the clamp
    u_wide   = (U_W + 1)'(depth_cl) + (U_W + 1)'(U_BIAS);

    s1_nxt.action = in_action;
    s1_nxt.clip   = clamp && (action_t'(in_action) != ACT_PASS);
    s1_nxt.vx     = in_vanish_x;
    s1_nxt.vy     = in_vanish_y;
    s1_nxt.dx     = $signed({tx[COORD_W-1], tx}) - $signed({in_vanish_x[COORD_W-1], in_vanish_x});
    s1_nxt.dy     = $signed({ty[COORD_W-1], ty}) - $signed({in_vanish_y[COORD_W-1], in_vanish_y});
    s1_nxt.px     = in_point_x;
    s1_nxt.py     = in_point_y;
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    u_r  <= u_wide[U_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Stages 2 to 5: factor unit, payload waits alongside
  // ---------------------------------------------------------------------
  logic                f_valid;
  logic [FACTOR_W-1:0] factor;
  item_t               dly_r [FACTOR_LAT];

  vppt_factor u_factor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_valid_r),
    .in_u       (u_r),
    .out_valid  (f_valid),
    .out_factor (factor)
  );

  always_ff @(posedge clk) begin
    dly_r[0] <= s1_r;
    for (int i = 1; i < FACTOR_LAT; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: blend products
  // ---------------------------------------------------------------------
  logic signed [44:0] mx_r, my_r, mx_nxt, my_nxt;
  item_t              s6_r;
  logic               s6_valid_r;

  always_comb begin
    mx_nxt = $signed({1'b0, factor}) * dly_r[FACTOR_LAT-1].dx;
    my_nxt = $signed({1'b0, factor}) * dly_r[FACTOR_LAT-1].dy;
  end

  always_ff @(posedge clk) begin
    mx_r <= mx_nxt;
    my_r <= my_nxt;
    s6_r <= dly_r[FACTOR_LAT-1];
  end

  // ---------------------------------------------------------------------
  // Stage 7: round half up, add vanishing point, saturate
  // ---------------------------------------------------------------------
  function automatic logic [COORD_W:0] blend_sat(input logic signed [44:0]        m,
                                                 input logic signed [COORD_W-1:0] v);
    logic signed [44:0] mr;
    logic signed [28:0] p;
    logic signed [29:0] res;
    mr  = (m + 45'sd32768) >>> 16;
    p   = mr[28:0];
    res = $signed({{6{v[COORD_W-1]}}, v}) + $signed({p[28], p});
    if (res > 30'sd8388607) begin
      return {1'b1, 24'h7FFFFF};
    end else if (res < -30'sd8388608) begin
      return {1'b1, 24'h800000};
    end
    return {1'b0, res[COORD_W-1:0]};
  endfunction

  logic [COORD_W:0]          bx, by;
  logic signed [COORD_W-1:0] ox_nxt, oy_nxt;
  logic                      oc_nxt;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic                      out_clipped_r, out_valid_r;

  always_comb begin
    bx = blend_sat(mx_r, s6_r.vx);
    by = blend_sat(my_r, s6_r.vy);
    if (action_t'(s6_r.action) == ACT_PASS) begin
      ox_nxt = s6_r.px;
      oy_nxt = s6_r.py;
      oc_nxt = 1'b0;
    end else begin
      ox_nxt = bx[COORD_W-1:0];
      oy_nxt = by[COORD_W-1:0];
      oc_nxt = s6_r.clip || bx[COORD_W] || by[COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    out_x_r       <= ox_nxt;
    out_y_r       <= oy_nxt;
    out_clipped_r <= oc_nxt;
  end

  // Valid bits advance with the data; no stall ever holds them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s6_valid_r  <= f_valid;
      out_valid_r <= s6_valid_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_clipped = out_clipped_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_busy_low: assert property (@(posedge clk) rst_n && $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(accept, PIPE_LAT))
    else $error("result strobe not aligned to its transfer");

  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept && (in_action == ACT_PASS), PIPE_LAT) |->
      out_valid && !out_clipped && (out_x == $past(in_point_x, PIPE_LAT)) &&
      (out_y == $past(in_point_y, PIPE_LAT)))
    else $error("pass-through point altered");

  a_unit_factor: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept && (in_action == ACT_BACK) && (in_intercept == '0), PIPE_LAT) |->
      !out_clipped && (out_x == $past(in_point_x, PIPE_LAT)) &&
      (out_y == $past(in_point_y, PIPE_LAT)))
    else $error("zero depth did not give unit factor");

endmodule

FILE: tb/sv/vanishing_plane_point_transform_tb.sv
`timescale 1ns / 1ps

module vanishing_plane_point_transform_tb;
  import vppt_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One transformed point as the block presents it on its result ports
  typedef struct {
    coord_t x;
    coord_t y;
    logic   clipped;
  } point_result_t;

  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
  // Depth at which the factor reaches 4.0, in coordinate units
  localparam int     CLAMP_DEPTH = -2 * DEPTH_UNITS * (2 ** COORD_FRAC_BITS);
  localparam int     RANDOM_POINTS = 1600;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_action = ACT_PASS;
  coord_t     in_point_x = '0;
  coord_t     in_point_y = '0;
  coord_t     in_intercept = '0;
  coord_t     in_vanish_x = '0;
  coord_t     in_vanish_y = '0;
  logic       out_valid;
  coord_t     out_x;
  coord_t     out_y;
  logic       out_clipped;

  // Results predicted for every accepted transfer, oldest first
  point_result_t pending_results[$];
  int            mismatch_count = 0;
  // Set to run a stretch of back-to-back transfers with no idle cycles
  bit            no_idle = 1'b0;

  vanishing_plane_point_transform dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_intercept(in_intercept),
    .in_vanish_x (in_vanish_x),
    .in_vanish_y (in_vanish_y),
    .out_valid   (out_valid),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_clipped (out_clipped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // floor(num / den) for den > 0; plain division truncates toward zero
  function automatic longint floor_quot(input longint num, input longint den);
    if (num >= 0) begin
      return num / den;
    end
    return -((-num + den - 1) / den);
  endfunction

  // 2^(-r/E) in Q0.30 from the alternating series in z = r*ln2/E
  function automatic longint exp2_frac_q30(input longint r);
    logic [63:0] z48;
    logic [63:0] z;
    logic [63:0] term;
    longint      acc;
    z48  = (64'(r) * LN2_Q48) / 64'(EXP_TABLE_ENTRIES);
    z    = (z48 + (64'd1 << 17)) >> 18;
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int k = 1; k <= 24; k++) begin
      term = ((term * z) >> 30) / 64'(k);
      if (k[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return acc;
  endfunction

  // Blend factor 0.5^(depth/750) in unsigned Q3.16; flags the depth clamp
  function automatic longint depth_factor_q16(input longint depth, inout bit clip);
    longint den;
    longint n;
    longint q;
    longint r;
    longint shift;
    logic [63:0] t;
    den = longint'(DEPTH_UNITS) * (64'sd1 <<< COORD_FRAC_BITS);
    if (depth < CLAMP_DEPTH) begin
      depth = CLAMP_DEPTH;
      clip  = 1'b1;
    end
    // Round the table index half up, then split it into octave and step
    n     = floor_quot(2 * depth * EXP_TABLE_ENTRIES + den, 2 * den);
    q     = floor_quot(n, EXP_TABLE_ENTRIES);
    r     = n - q * EXP_TABLE_ENTRIES;
    t     = 64'(exp2_frac_q30(r));
    shift = 14 + q;
    if (shift >= 63) begin
      return 0;
    end
    return longint'((t + (64'd1 << (shift - 1))) >> shift);
  endfunction

  // v + f*(target - v), product rounded half up to Q15.8, sum saturated
  function automatic coord_t blend_toward(input longint v, input longint target,
                                          input longint f, inout bit clip);
    longint sum;
    sum = v + ((f * (target - v) + 32768) >>> 16);
    if (sum > COORD_MAX) begin
      sum  = COORD_MAX;
      clip = 1'b1;
    end else if (sum < COORD_MIN) begin
      sum  = COORD_MIN;
      clip = 1'b1;
    end
    return coord_t'(sum);
  endfunction

  function automatic point_result_t transform_point(input action_t act, input coord_t px,
                                                    input coord_t py, input coord_t ic,
                                                    input coord_t vx, input coord_t vy);
    point_result_t res;
    bit            clip;
    longint        f;
    clip = 1'b0;
    res.x = px;
    res.y = py;
    case (act)
      ACT_SIDE: begin
        f     = depth_factor_q16(longint'(px), clip);
        res.x = blend_toward(longint'(vx), longint'(ic), f, clip);
        res.y = blend_toward(longint'(vy), longint'(py), f, clip);
      end
      ACT_FLOOR: begin
        f     = depth_factor_q16(longint'(py), clip);
        res.x = blend_toward(longint'(vx), longint'(px), f, clip);
        res.y = blend_toward(longint'(vy), longint'(ic), f, clip);
      end
      ACT_BACK: begin
        f     = depth_factor_q16(longint'(ic), clip);
        res.x = blend_toward(longint'(vx), longint'(px), f, clip);
        res.y = blend_toward(longint'(vy), longint'(py), f, clip);
      end
      default: begin
      end
    endcase
    res.clipped = clip;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every strobe is compared against the oldest prediction.
  // Sampling at the rising edge sees the values of the cycle that edge ends.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    point_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with nothing outstanding: out_x %0d out_y %0d", out_x, out_y);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_x !== want.x) begin
          $error("out_x mismatch: expected %0d, actual %0d", want.x, out_x);
          mismatch_count++;
        end
        if (out_y !== want.y) begin
          $error("out_y mismatch: expected %0d, actual %0d", want.y, out_y);
          mismatch_count++;
        end
        if (out_clipped !== want.clipped) begin
          $error("out_clipped mismatch: expected %0b, actual %0b", want.clipped, out_clipped);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, otherwise an idle gap, now and then a long pause
  function automatic int next_gap();
    int pick;
    if (no_idle) begin
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  // Coordinates weighted toward the depths where the factor does something
  // interesting, the clamp edge and the limits of the range
  function automatic coord_t random_coord();
    case ($urandom_range(9))
      5, 6: return coord_t'(int'($urandom_range(1200000)) - 600000);
      7: return coord_t'(CLAMP_DEPTH + int'($urandom_range(6)) - 3);
      8: begin
        case ($urandom_range(4))
          0: return coord_t'(COORD_MAX);
          1: return coord_t'(COORD_MIN);
          2: return '0;
          3: return coord_t'(-1);
          default: return coord_t'(1);
        endcase
      end
      9: return coord_t'(int'($urandom_range(2048)) - 1024);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Present one point, hold it until the block takes it, then idle for the gap that next_gap picks, if any.
  // Called just after a rising edge; start is only ever raised here.
  task automatic send_point(input action_t act, input coord_t px, input coord_t py,
                            input coord_t ic, input coord_t vx, input coord_t vy);
    point_result_t predicted;
    int            gap;
    predicted = transform_point(act, px, py, ic, vx, vy);
    start        <= 1'b1;
    in_action    <= act;
    in_point_x   <= px;
    in_point_y   <= py;
    in_intercept <= ic;
    in_vanish_x  <= vx;
    in_vanish_y  <= vy;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    pending_results.push_back(predicted);
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the input side off until every outstanding result has come back
  task automatic wait_for_drain();
    if (pending_results.size() != 0) begin
      start <= 1'b0;
      while (pending_results.size() != 0) begin
        @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pass-through returns the point as given, whatever the plane says
  task automatic test_pass_through();
    send_point(ACT_PASS, coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
               coord_t'(COORD_MAX), '0);
    send_point(ACT_PASS, coord_t'(COORD_MIN), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
               coord_t'(COORD_MIN), coord_t'(-1));
  endtask

  // Zero depth gives factor one, so the output lands on the target
  task automatic test_zero_depth();
    send_point(ACT_SIDE, '0, coord_t'(-7777), coord_t'(5000), coord_t'(1000),
               coord_t'(-2000));
    send_point(ACT_FLOOR, coord_t'(123456), '0, coord_t'(-98765), coord_t'(-4096),
               coord_t'(300));
    send_point(ACT_BACK, coord_t'(-55555), coord_t'(44444), '0, coord_t'(777),
               coord_t'(-888));
  endtask

  // Just past the clamp depth sets clipped; exactly at it does not
  task automatic test_depth_clamp();
    send_point(ACT_SIDE, coord_t'(CLAMP_DEPTH - 1), coord_t'(2560), coord_t'(-2560),
               coord_t'(100), coord_t'(-100));
    send_point(ACT_BACK, coord_t'(512), coord_t'(-512), coord_t'(COORD_MIN), '0, '0);
    send_point(ACT_FLOOR, coord_t'(1024), coord_t'(CLAMP_DEPTH), coord_t'(256),
               coord_t'(-300), coord_t'(600));
    send_point(ACT_BACK, coord_t'(-1024), coord_t'(768), coord_t'(CLAMP_DEPTH + 1),
               coord_t'(50), coord_t'(60));
  endtask

  // Deep positive depth drives the factor to zero: the vanishing point comes out
  task automatic test_factor_underflow();
    send_point(ACT_BACK, coord_t'(COORD_MIN), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
               coord_t'(12345), coord_t'(-54321));
    send_point(ACT_SIDE, coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
               coord_t'(-1), coord_t'(1));
  endtask

  // Factor four on a wide span pushes both outputs into saturation
  task automatic test_saturation();
    send_point(ACT_BACK, coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(CLAMP_DEPTH),
               coord_t'(COORD_MIN), coord_t'(COORD_MAX));
    send_point(ACT_BACK, coord_t'(COORD_MIN), coord_t'(COORD_MAX), coord_t'(CLAMP_DEPTH),
               coord_t'(COORD_MAX), coord_t'(COORD_MIN));
    send_point(ACT_FLOOR, coord_t'(4000000), coord_t'(COORD_MIN), coord_t'(COORD_MAX),
               coord_t'(-4000000), coord_t'(COORD_MIN));
  endtask

  // Every field at its top, then at its bottom, for each plane
  task automatic test_field_extremes();
    send_point(ACT_SIDE, coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
               coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    send_point(ACT_FLOOR, coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
               coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    send_point(ACT_BACK, coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
               coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    send_point(ACT_SIDE, coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
               coord_t'(COORD_MIN), coord_t'(COORD_MIN));
    send_point(ACT_FLOOR, coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
               coord_t'(COORD_MIN), coord_t'(COORD_MIN));
    send_point(ACT_BACK, coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
               coord_t'(COORD_MIN), coord_t'(COORD_MIN));
  endtask

  // Random points in chunks; some chunks run flat out with no idle cycles,
  // and half-way through the input side drains the pipeline completely
  task automatic test_random_points();
    for (int i = 0; i < RANDOM_POINTS; i++) begin
      if (i % 200 == 0) begin
        no_idle = ($urandom_range(3) == 0);
      end
      if (i == RANDOM_POINTS / 2) begin
        wait_for_drain();
      end
      send_point(action_t'($urandom_range(3)), random_coord(), random_coord(),
                 random_coord(), random_coord(), random_coord());
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pass_through();
    test_zero_depth();
    test_depth_clamp();
    test_factor_underflow();
    test_saturation();
    test_field_extremes();
    wait_for_drain();
    test_random_points();

    // Drop start, let the pipeline empty, then keep watching for strays
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/vppt_pkg.sv
rtl/vppt_factor.sv
rtl/vanishing_plane_point_transform.sv
tb/sv/vanishing_plane_point_transform_tb.sv
